/* src/gvts_pkg.sv */
// ----------------------------------------------------------------------------
// gvts_pkg: shared types and constants of the Gouraud shading unit
// Payload structs, configuration register indexes and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package gvts_pkg;

  typedef struct packed {
    logic               mode;
    logic [1:0]         corner;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        bary_0;
    logic [16:0]        bary_1;
    logic [16:0]        bary_2;
  } in_item_t;

  typedef struct packed {
    logic               is_fragment;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_z;
    logic [7:0]         gray;
  } out_item_t;

  localparam logic [2:0] CfgRow0  = 3'd0;
  localparam logic [2:0] CfgRow3  = 3'd3;
  localparam logic [2:0] CfgLight = 3'd4;

  localparam int unsigned DivBits = 56;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIGHT,
    ST_MAC,
    ST_INTEN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FRAG,
    ST_GRAY,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture the accepted item
    logic       clr_acc;    // clear the accumulator
    logic       mac_light;  // multiply-accumulate a normal term
    logic       mac_mat;    // multiply-accumulate a matrix term
    logic       mac_frag;   // multiply-accumulate a fragment term
    logic [1:0] row;
    logic [1:0] col;
    logic       save_row;   // store the accumulator as row result
    logic       store_int;  // write the corner intensity
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_save;
    logic       gray_mul;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic div_done;
  } sts_t;

endpackage

/* src/gvts_div.sv */
// ----------------------------------------------------------------------------
// gvts_div: serial signed divider
// Restoring divider, one quotient bit a cycle, with zero-divisor and range
// saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module gvts_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [37:0] num_i,
  input  logic signed [37:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  localparam int unsigned NB = gvts_pkg::DivBits;

  logic [NB-1:0] rem_q, rem_d;
  logic [NB-1:0] quo_q, quo_d;
  logic [NB-1:0] dvs_q, dvs_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          neg_q, neg_d;
  logic          zero_q, zero_d;
  logic [1:0]    zsgn_q, zsgn_d;
  logic          done_q, done_d;
  logic signed [31:0] res_q, res_d;

  logic [NB-1:0]  num_abs;
  logic [NB-1:0]  den_abs;
  logic [NB:0]    trial;
  logic [NB-1:0]  shifted;
  logic signed [NB:0] sq;

  always_comb begin
    num_abs = num_i[37] ? NB'(-{{(NB-38){num_i[37]}}, num_i}) << 16
                        : NB'({{(NB-38){1'b0}}, num_i}) << 16;
    den_abs = den_i[37] ? NB'(-{{(NB-38){den_i[37]}}, den_i})
                        : NB'({{(NB-38){1'b0}}, den_i});
    shifted = {rem_q[NB-2:0], quo_q[NB-1]};
    trial   = {1'b0, shifted} - {1'b0, dvs_q};
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; zero_d = zero_q; zsgn_d = zsgn_q;
    done_d = 1'b0; res_d = res_q;
    sq = '0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_abs;
      dvs_d  = den_abs;
      cnt_d  = 6'(NB);
      busy_d = 1'b1;
      neg_d  = num_i[37] ^ den_i[37];
      zero_d = (den_i == '0);
      zsgn_d = {num_i[37], num_i != '0};
    end else if (busy_q) begin
      if (zero_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        priority if (!zsgn_q[0]) res_d = '0;
        else if (zsgn_q[1]) res_d = 32'sh8000_0000;
        else res_d = 32'sh7fff_ffff;
      end else if (cnt_q != '0) begin
        quo_d = {quo_q[NB-2:0], ~trial[NB]};
        rem_d = trial[NB] ? shifted : trial[NB-1:0];
        cnt_d = cnt_q - 6'd1;
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
        sq = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
        priority if (sq > $signed((NB+1)'(33'sh0_7fff_ffff))) res_d = 32'sh7fff_ffff;
        else if (sq < -$signed((NB+1)'(33'sh0_8000_0000))) res_d = 32'sh8000_0000;
        else res_d = sq[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; neg_q <= neg_d;
    zero_q <= zero_d; zsgn_q <= zsgn_d; res_q <= res_d;
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

/* src/gvts_dp.sv */
// ----------------------------------------------------------------------------
// gvts_dp: datapath of the shading unit
// One shared 18x18 signed multiplier with accumulator, row result registers,
// corner intensities, the serial divider and the result register.
// ----------------------------------------------------------------------------
module gvts_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gvts_pkg::cmd_t      cmd_i,
  output gvts_pkg::sts_t      sts_o,
  input  gvts_pkg::in_item_t  item_i,
  input  logic [63:0]         row_i [4],
  input  logic [47:0]         light_i,
  output gvts_pkg::out_item_t res_o
);

  gvts_pkg::in_item_t item_q;
  logic signed [39:0] acc_q;
  logic signed [37:0] rowv_q [4];
  logic [14:0]        inten_q [3];
  logic signed [31:0] scr_q [3];
  logic [7:0]         gray_q;
  gvts_pkg::out_item_t res_q;

  logic signed [17:0] ma, mb;
  logic signed [35:0] prod;
  logic               div_done;
  logic signed [31:0] div_quo;
  logic signed [37:0] div_num;
  logic [47:0]        g;

  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd_i.mac_light) begin
      unique case (cmd_i.col)
        2'd0:    ma = 18'(item_q.norm_x);
        2'd1:    ma = 18'(item_q.norm_y);
        default: ma = 18'(item_q.norm_z);
      endcase
      mb = 18'($signed(light_i[16*cmd_i.col +: 16]));
    end else if (cmd_i.mac_mat) begin
      mb = 18'($signed(row_i[cmd_i.row][16*cmd_i.col +: 16]));
      unique case (cmd_i.col)
        2'd0:    ma = 18'(item_q.pos_x);
        2'd1:    ma = 18'(item_q.pos_y);
        2'd2:    ma = 18'(item_q.pos_z);
        default: ma = 18'sd4096;
      endcase
    end else if (cmd_i.mac_frag) begin
      ma = $signed({3'b000, inten_q[cmd_i.col]});
      unique case (cmd_i.col)
        2'd0:    mb = $signed({1'b0, item_q.bary_0});
        2'd1:    mb = $signed({1'b0, item_q.bary_1});
        default: mb = $signed({1'b0, item_q.bary_2});
      endcase
    end
    prod = ma * mb;
    div_num = rowv_q[cmd_i.div_sel];
    // The weighted sum of three intensities can reach 33 bits.
    g = 48'(acc_q[33:0]) * 48'd255;
  end

  gvts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (rowv_q[3]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inten_q <= '{default: '0};
    end else if (cmd_i.store_int && item_q.corner != 2'd3) begin
      if (acc_q <= 0) inten_q[item_q.corner] <= '0;
      else if ((acc_q >>> 14) > 40'sd16384) inten_q[item_q.corner] <= 15'd16384;
      else inten_q[item_q.corner] <= acc_q[28:14];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.clr_acc) acc_q <= '0;
    else if (cmd_i.mac_light || cmd_i.mac_mat || cmd_i.mac_frag) acc_q <= acc_q + 40'(prod);
    if (cmd_i.save_row) rowv_q[cmd_i.row] <= acc_q[37:0];
    if (cmd_i.div_save) scr_q[cmd_i.div_sel] <= div_quo;
    if (cmd_i.gray_mul) gray_q <= (g[47:30] > 18'd255) ? 8'd255 : g[37:30];
    if (cmd_i.out_load) begin
      res_q.is_fragment <= item_q.mode;
      res_q.screen_x    <= item_q.mode ? 32'sd0 : scr_q[0];
      res_q.screen_y    <= item_q.mode ? 32'sd0 : scr_q[1];
      res_q.screen_z    <= item_q.mode ? 32'sd0 : scr_q[2];
      res_q.gray        <= item_q.mode ? gray_q : 8'd0;
    end
  end

  assign sts_o.mode     = item_q.mode;
  assign sts_o.div_done = div_done;
  assign res_o          = res_q;

endmodule

/* src/gvts_ctrl.sv */
// ----------------------------------------------------------------------------
// gvts_ctrl: controller of the shading unit
// Sequences the multiply-accumulate steps, the three divisions and the
// result handshake.
// ----------------------------------------------------------------------------
module gvts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gvts_pkg::cmd_t cmd_o,
  input  gvts_pkg::sts_t sts_i
);

  gvts_pkg::state_e state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [1:0] col_q, col_d;
  logic       ov_q, ov_d;

  always_comb begin
    state_d = state_q; row_d = row_q; col_d = col_q; ov_d = ov_q;
    cmd_o = '0;
    cmd_o.row = row_q;
    cmd_o.col = col_q;
    cmd_o.div_sel = row_q;
    in_stall_o = 1'b1;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      gvts_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.clr_acc = 1'b1;
          col_d = '0; row_d = '0;
          state_d = gvts_pkg::ST_LIGHT;
        end
      end
      gvts_pkg::ST_LIGHT: begin
        if (sts_i.mode) begin
          state_d = gvts_pkg::ST_FRAG;
        end else begin
          cmd_o.mac_light = 1'b1;
          col_d = col_q + 2'd1;
          if (col_q == 2'd2) begin
            col_d = '0;
            state_d = gvts_pkg::ST_INTEN;
          end
        end
      end
      gvts_pkg::ST_INTEN: begin
        cmd_o.store_int = 1'b1;
        cmd_o.clr_acc = 1'b1;
        state_d = gvts_pkg::ST_MAC;
      end
      gvts_pkg::ST_MAC: begin
        if (col_q == 2'd0 && row_q == 2'd0 && 1'b0) cmd_o.clr_acc = 1'b1;
        cmd_o.mac_mat = 1'b1;
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) state_d = gvts_pkg::ST_DIV_START;
      end
      gvts_pkg::ST_DIV_START: begin
        // Save the finished row; after rows 0-2 the next row's terms follow.
        cmd_o.save_row = 1'b1;
        cmd_o.clr_acc = 1'b1;
        col_d = '0;
        if (row_q == 2'd3) begin
          row_d = '0;
          state_d = gvts_pkg::ST_DIV_WAIT;
        end else begin
          row_d = row_q + 2'd1;
          state_d = gvts_pkg::ST_MAC;
        end
      end
      gvts_pkg::ST_DIV_WAIT: begin
        if (col_q == 2'd0) begin
          cmd_o.div_start = 1'b1;
          col_d = 2'd1;
        end else if (sts_i.div_done) begin
          cmd_o.div_save = 1'b1;
          col_d = 2'd0;
          if (row_q == 2'd2) state_d = gvts_pkg::ST_OUT;
          else row_d = row_q + 2'd1;
        end
      end
      gvts_pkg::ST_FRAG: begin
        cmd_o.mac_frag = 1'b1;
        col_d = col_q + 2'd1;
        if (col_q == 2'd2) state_d = gvts_pkg::ST_GRAY;
      end
      gvts_pkg::ST_GRAY: begin
        cmd_o.gray_mul = 1'b1;
        state_d = gvts_pkg::ST_OUT;
      end
      gvts_pkg::ST_OUT: begin
        if (!ov_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = gvts_pkg::ST_IDLE;
        end
      end
      default: state_d = gvts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gvts_pkg::ST_IDLE;
      row_q <= '0; col_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; row_q <= row_d; col_q <= col_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !cmd_o.div_start)
    else $error("divider restarted back to back");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == gvts_pkg::ST_IDLE)
    else $error("item loaded outside idle");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |-> !cmd_o.out_load)
    else $error("stalled result overwritten");

endmodule

/* src/gouraud_vertex_transform_shade.sv */
// ----------------------------------------------------------------------------
// gouraud_vertex_transform_shade: Gouraud vertex transform and shade unit
// Top level joining configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i/in_stall_o, one beat per item; each gives
// one result beat on out_valid_o/out_stall_i. A vertex beat computes and
// stores its corner intensity (three multiplies), then sixteen multiplies on
// the shared multiplier, then three serial divisions. A fragment beat takes
// three multiplies and the gray scaling.
// One item is in work at a time. The result register holds the finished beat
// while the receiver stalls; the next item is accepted meanwhile and waits
// only for the register before its result is loaded.
// Configuration writes (cfg_valid_i/cfg_ready_o) are always taken and must
// only be issued while the block is idle. Reset clears the matrix, the light
// direction and the stored corner intensities; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gouraud_vertex_transform_shade (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gvts_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gvts_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  logic [63:0] row_q [4];
  logic [47:0] light_q;
  gvts_pkg::cmd_t cmd;
  gvts_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '{default: '0};
      light_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i <= gvts_pkg::CfgRow3) row_q[cfg_index_i[1:0]] <= cfg_data_i;
      else if (cfg_index_i == gvts_pkg::CfgLight) light_q <= cfg_data_i[47:0];
    end
  end

  gvts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gvts_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .item_i  (in_item_i),
    .row_i   (row_q),
    .light_i (light_q),
    .res_o   (out_item_o)
  );

endmodule
